>>> src/rank_sequence_store_unit_macros.svh
// Assertion helpers for the rank sequence store.
// Each one samples on clock and is off while reset is high.
`ifndef RANK_SEQUENCE_STORE_UNIT_MACROS_SVH
`define RANK_SEQUENCE_STORE_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define RSS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Consequent holds in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

>>> src/rss_pkg.sv
package rss_pkg;

   localparam int CAPACITY = 16;
   localparam int ELEM_W   = 32;
   localparam int HANDLE_W = $clog2(CAPACITY);
   localparam int LINK_W   = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_RANK   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_RANK  = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

endpackage

>>> src/rank_sequence_store_unit.sv
// Rank sequence store: an ordered list of up to 16 elements kept as linked
// nodes in two small memories (element per handle, successor per handle).
// Handles are handed out in order 0, 1, 2 ... since nodes are never removed.
//
// Request channel: a beat is taken at the rising edge where start is high
// and busy is low; req_operation picks insert at rank, read at rank or rank
// of handle. Result channel: rsp_valid strobes for one cycle with the result
// beat; the receiver cannot hold it off, so the block never stalls on output.
// Rejected requests, unused codes and inserts at rank 0 are answered
// straight from the idle state. An insert at rank r > 0 walks to rank
// r - 1, then links the new node in (S_SPLICE, then S_LINK); a read at
// rank r walks to rank r and answers from S_READ. Rank of handle walks
// from the head until the handle is met or all count nodes are passed.
// The walk follows one link per cycle through the registered read port of
// the link memory; busy is high for the whole walk and drops in the result
// cycle, where the next beat may already be taken: beats do not overlap.
// Reset empties the list (head at end marker, count zero); memory contents
// are left as they are and are only read once written.
module rank_sequence_store_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_operation,
   input  logic [rss_pkg::LINK_W-1:0]   req_rank,
   input  logic [rss_pkg::ELEM_W-1:0]   req_element_in,
   input  logic [rss_pkg::HANDLE_W-1:0] req_handle_in,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [rss_pkg::HANDLE_W-1:0] rsp_handle_out,
   output logic [rss_pkg::ELEM_W-1:0]   rsp_element_out,
   output logic [rss_pkg::HANDLE_W-1:0] rsp_rank_out,
   output logic [rss_pkg::LINK_W-1:0]   rsp_count_out
);

   `include "rank_sequence_store_unit_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_READ,
      S_SPLICE,
      S_LINK
   } state_type;

   // sequencer and list state
   state_type                      state_ff, state_in;
   rss_pkg::op_type                op_ff, op_in;
   logic [rss_pkg::LINK_W-1:0]     target_ff, target_in;
   logic [rss_pkg::LINK_W-1:0]     idx_ff, idx_in;
   logic                           first_ff, first_in;
   logic [rss_pkg::HANDLE_W-1:0]   handle_ff, handle_in;
   logic [rss_pkg::HANDLE_W-1:0]   prev_ff, prev_in;
   logic [rss_pkg::ELEM_W-1:0]     elem_ff, elem_in;
   logic [rss_pkg::LINK_W-1:0]     head_ff, head_in;
   logic [rss_pkg::LINK_W-1:0]     count_ff, count_in;

   // registered result beat
   logic                           rsp_valid_ff, rsp_valid_in;
   rss_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [rss_pkg::HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [rss_pkg::ELEM_W-1:0]     rsp_elem_ff, rsp_elem_in;
   logic [rss_pkg::HANDLE_W-1:0]   rsp_rank_ff, rsp_rank_in;
   logic [rss_pkg::LINK_W-1:0]     rsp_count_ff, rsp_count_in;

   // memories with registered read data
   logic [rss_pkg::LINK_W-1:0]     link_mem_ff [rss_pkg::CAPACITY];
   logic [rss_pkg::ELEM_W-1:0]     elem_mem_ff [rss_pkg::CAPACITY];
   logic [rss_pkg::LINK_W-1:0]     link_q_ff;
   logic [rss_pkg::ELEM_W-1:0]     elem_q_ff;

   logic                           link_we;
   logic [rss_pkg::HANDLE_W-1:0]   link_waddr;
   logic [rss_pkg::LINK_W-1:0]     link_wdata;
   logic                           elem_we;
   logic [rss_pkg::HANDLE_W-1:0]   elem_waddr;
   logic [rss_pkg::HANDLE_W-1:0]   rd_addr;

   logic [rss_pkg::LINK_W-1:0]     node;
   logic [rss_pkg::HANDLE_W-1:0]   new_handle;
   logic                           accept;

   assign accept     = start && (state_ff == S_IDLE);
   assign new_handle = count_ff[rss_pkg::HANDLE_W-1:0];

   // Current node of the walk: the head on the first step, else the link
   // just read back.
   assign node    = first_ff ? head_ff : link_q_ff;
   assign rd_addr = node[rss_pkg::HANDLE_W-1:0];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      target_in     = target_ff;
      idx_in        = idx_ff;
      first_in      = first_ff;
      handle_in     = handle_ff;
      prev_in       = prev_ff;
      elem_in       = elem_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_count_in  = rsp_count_ff;
      link_we       = 1'b0;
      link_waddr    = new_handle;
      link_wdata    = head_ff;
      elem_we       = 1'b0;
      elem_waddr    = new_handle;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // prepare a rejection beat; successful paths overwrite it
               rsp_status_in = rss_pkg::STAT_BAD_RANK;
               rsp_handle_in = '0;
               rsp_elem_in   = '0;
               rsp_rank_in   = '0;
               rsp_count_in  = count_ff;
               op_in         = rss_pkg::op_type'(req_operation);
               idx_in        = '0;
               first_in      = 1'b1;
               handle_in     = req_handle_in;
               elem_in       = req_element_in;
               case (rss_pkg::op_type'(req_operation))
                  rss_pkg::OP_INSERT: begin
                     if (req_rank > count_ff) begin
                        rsp_valid_in = 1'b1;
                     end else if (count_ff == rss_pkg::LINK_W'(rss_pkg::CAPACITY)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rss_pkg::STAT_FULL;
                     end else begin
                        elem_we = 1'b1;
                        if (req_rank == '0) begin
                           // new head: splice in at once
                           link_we       = 1'b1;
                           head_in       = count_ff;
                           count_in      = count_ff + 1'b1;
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = rss_pkg::STAT_OK;
                           rsp_handle_in = new_handle;
                           rsp_elem_in   = req_element_in;
                           rsp_count_in  = count_ff + 1'b1;
                        end else begin
                           // walk to the predecessor
                           target_in = req_rank - 1'b1;
                           state_in  = S_WALK;
                        end
                     end
                  end
                  rss_pkg::OP_READ: begin
                     if (req_rank >= count_ff) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        target_in = req_rank;
                        state_in  = S_WALK;
                     end
                  end
                  rss_pkg::OP_RANK: begin
                     state_in = S_WALK;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_WALK: begin
            if (op_ff == rss_pkg::OP_RANK) begin
               if (idx_ff == count_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = rss_pkg::STAT_NOT_FOUND;
                  state_in      = S_IDLE;
               end else if (rd_addr == handle_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = rss_pkg::STAT_OK;
                  rsp_rank_in   = idx_ff[rss_pkg::HANDLE_W-1:0];
                  state_in      = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  first_in = 1'b0;
               end
            end else if (idx_ff == target_ff) begin
               // target node reached; its element or successor is read now
               prev_in  = rd_addr;
               state_in = (op_ff == rss_pkg::OP_READ) ? S_READ : S_SPLICE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               first_in = 1'b0;
            end
         end

         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = rss_pkg::STAT_OK;
            rsp_handle_in = prev_ff;
            rsp_elem_in   = elem_q_ff;
            state_in      = S_IDLE;
         end

         S_SPLICE: begin
            // new node takes over the predecessor's successor
            link_we    = 1'b1;
            link_wdata = link_q_ff;
            state_in   = S_LINK;
         end

         S_LINK: begin
            // predecessor now points at the new node
            link_we       = 1'b1;
            link_waddr    = prev_ff;
            link_wdata    = count_ff;
            count_in      = count_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = rss_pkg::STAT_OK;
            rsp_handle_in = new_handle;
            rsp_elem_in   = elem_ff;
            rsp_count_in  = count_ff + 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= rss_pkg::LINK_W'(rss_pkg::CAPACITY);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
      op_ff         <= op_in;
      target_ff     <= target_in;
      idx_ff        <= idx_in;
      handle_ff     <= handle_in;
      prev_ff       <= prev_in;
      elem_ff       <= elem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem_ff[link_waddr] <= link_wdata;
      end
      link_q_ff <= link_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem_ff[elem_waddr] <= req_element_in;
      end
      elem_q_ff <= elem_mem_ff[rd_addr];
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_handle_ff;
   assign rsp_element_out = rsp_elem_ff;
   assign rsp_rank_out    = rsp_rank_ff;
   assign rsp_count_out   = rsp_count_ff;

   // every accepted beat either answers next cycle or starts a walk
   `RSS_ASSERT_NEXT(a_accept_acts, start && !busy, busy || rsp_valid)
   // results are only shown once the sequencer is back at rest
   `RSS_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy)
   // the list only grows together with a reported insert
   `RSS_ASSERT_SAME(a_count_reported, !$past(reset) && !$stable(count_ff),
      rsp_valid && rsp_count_out == count_ff)

endmodule
